/* sv/tpdd_pkg.sv */
// Package: constants, types and helpers for the touch packet decoder.
package tpdd_pkg;
  localparam int PacketBytes = 11;
  localparam int TimeBits = 16;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] RegFormat  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegCalXLo  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegCalYLo  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegCalXHi  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegCalYHi  = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegSmooth  = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegJitter  = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegTapping = 3'd7;

  localparam logic [1:0] EvMotion  = 2'd0;
  localparam logic [1:0] EvPress   = 2'd1;
  localparam logic [1:0] EvRelease = 2'd2;

  localparam logic [0:0] OpByte = 1'b0;
  localparam logic [0:0] OpTick = 1'b1;

  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChT  = 8'h54;
  localparam logic [7:0] ChR  = 8'h52;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic last;
  } result_t;

  // shared divider request / response
  typedef struct packed {
    logic start;
    logic [31:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage

/* sv/tpdd_if.sv */
// Interfaces: input, output and configuration channels.
interface tpdd_in_if;
  logic valid;
  logic ready;
  logic [0:0] opcode;
  logic [7:0] rx_byte;
  modport source (output valid, opcode, rx_byte, input ready);
  modport sink (input valid, opcode, rx_byte, output ready);
endinterface

interface tpdd_out_if;
  logic valid;
  logic ready;
  logic [1:0] event_kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic last;
  modport source (output valid, event_kind, pos_x, pos_y, last, input ready);
  modport sink (input valid, event_kind, pos_x, pos_y, last, output ready);
endinterface

interface tpdd_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/tpdd_div.sv */
// Shared restoring divider: unsigned 32 by 16, one quotient bit per cycle.
module tpdd_div (
  input  logic clk,
  input  logic rst,
  input  tpdd_pkg::div_req_t req,
  output tpdd_pkg::div_rsp_t rsp
);
  import tpdd_pkg::*;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] den;
  logic [5:0] cnt;
  logic busy;
  logic done;
  logic [16:0] trial;
  logic [16:0] shifted;

  assign shifted = {rem[15:0], quo[31]};
  assign trial = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
        cnt <= 6'd32;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = quo;
endmodule

/* sv/tpdd_core.sv */
// Sequencer: packet framing, decimal parse, calibration, smoothing, events.
module tpdd_core #(
  parameter int PACKET_BYTES = tpdd_pkg::PacketBytes,
  parameter int TIME_BITS = tpdd_pkg::TimeBits
) (
  input  logic clk,
  input  logic rst,
  tpdd_in_if.sink in_ch,
  tpdd_out_if.source out_ch,
  tpdd_cfg_if.sink cfg_ch,
  output tpdd_pkg::div_req_t dreq,
  input  tpdd_pkg::div_rsp_t drsp
);
  import tpdd_pkg::*;
  localparam int CntBits = $clog2(PACKET_BYTES + 1);
  localparam int IdxBits = $clog2(PACKET_BYTES);
  localparam logic [CntBits-1:0] Len = CntBits'(PACKET_BYTES);
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_BYTE, S_PARSE, S_CAL_START, S_CAL_WAIT,
    S_SM_START, S_SM_WAIT, S_EVENTS, S_OUT
  } state_t;

  state_t state;
  logic [1:0] format_mode;
  logic [9:0] cal_x_low, cal_y_low, cal_x_high, cal_y_high;
  logic [7:0] smoothness;
  logic [15:0] jitter_delay_ms, tapping_delay_ms;

  logic [CntBits-1:0] byte_count;
  logic [7:0] packet_store [PACKET_BYTES];
  logic [15:0] avg_x, avg_y;
  logic prev_touch, pen_was_up, pre_tap, release_pending;
  logic [15:0] release_countdown;
  logic [TIME_BITS-1:0] ms_since_up;

  logic [7:0] b;
  logic [IdxBits-1:0] pidx;
  logic axis;
  logic [1:0] pphase;
  logic neg;
  logic [15:0] mag;
  logic [9:0] raw_x, raw_y;
  logic [15:0] vx, vy;
  logic button;
  logic sign_q;
  result_t res [2];
  logic [1:0] nres;
  logic oidx;
  logic [7:0] cur;
  logic is_sp, is_dig;
  logic [19:0] mag10;
  logic [15:0] mag_sat;
  logic [15:0] mag_div;
  logic [9:0] lo_s, hi_s, raw_s;
  logic signed [11:0] den_s, diff_s;
  logic [10:0] den_abs, diff_abs;
  logic quo_big;
  logic signed [18:0] cal_v;
  logic [15:0] cal_sat;
  logic [15:0] avg_s, val_s;
  logic [23:0] sm_num;
  logic [CntBits-1:0] bc0;
  logic binary;
  logic [CntBits-1:0] plen;

  assign binary = format_mode[0];
  assign plen = binary ? CntBits'(3) : Len;
  assign cur = packet_store[pidx];
  assign is_sp = (cur == ChSpace) || (cur >= 8'h09 && cur <= ChCr);
  assign is_dig = (cur >= 8'h30) && (cur <= 8'h39);
  assign mag10 = {4'd0, mag} * 20'd10 + {16'd0, cur[3:0]};
  assign mag_sat = (mag10 > 20'd65535) ? 16'hffff : mag10[15:0];
  assign mag_div = format_mode[1] ? {2'b00, mag[15:2]} : mag;
  assign bc0 = (byte_count >= plen) ? '0 : byte_count;

  assign lo_s = axis ? cal_y_low : cal_x_low;
  assign hi_s = axis ? cal_y_high : cal_x_high;
  assign raw_s = axis ? raw_y : raw_x;
  assign den_s = (hi_s == lo_s) ? 12'sd1 : $signed({2'b00, hi_s}) - $signed({2'b00, lo_s});
  assign diff_s = $signed({2'b00, raw_s}) - $signed({2'b00, lo_s});
  assign den_abs = den_s[11] ? 11'(-den_s) : den_s[10:0];
  assign diff_abs = diff_s[11] ? 11'(-diff_s) : diff_s[10:0];
  assign sign_q = den_s[11] ^ diff_s[11];
  assign quo_big = |drsp.quo[31:17];
  assign cal_v = sign_q ? 19'sd8192 - $signed({2'b00, drsp.quo[16:0]})
                        : 19'sd8192 + $signed({2'b00, drsp.quo[16:0]});
  assign cal_sat = quo_big ? (sign_q ? 16'd0 : 16'hffff)
                 : (cal_v[18] ? 16'd0 : (cal_v > 19'sd65535 ? 16'hffff : cal_v[15:0]));
  assign avg_s = axis ? avg_y : avg_x;
  assign val_s = axis ? vy : vx;
  assign sm_num = avg_s * smoothness + {8'd0, val_s};

  assign in_ch.ready = (state == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.event_kind = res[oidx].event_kind;
  assign out_ch.pos_x = res[oidx].pos_x;
  assign out_ch.pos_y = res[oidx].pos_y;
  assign out_ch.last = (oidx == nres[0] - 1'b1) || (nres == 2'd2 && oidx);

  always_ff @(posedge clk) begin
    dreq.start <= !rst && (state == S_CAL_START || state == S_SM_START);
    if (rst) begin
      state <= S_IDLE;
      format_mode <= '0;
      cal_x_low <= 10'd128; cal_y_low <= 10'd128;
      cal_x_high <= 10'd896; cal_y_high <= 10'd896;
      smoothness <= 8'd9;
      jitter_delay_ms <= 16'd50;
      tapping_delay_ms <= '0;
      byte_count <= '0;
      avg_x <= '1; avg_y <= '1;
      prev_touch <= 1'b0; pen_was_up <= 1'b1; pre_tap <= 1'b0;
      release_pending <= 1'b0; release_countdown <= '0;
      ms_since_up <= '0;
      nres <= '0; oidx <= 1'b0;
      dreq.num <= '0; dreq.den <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_ch.valid) begin
            case (cfg_ch.index)
              RegFormat:  format_mode <= cfg_ch.data[1:0];
              RegCalXLo:  cal_x_low <= cfg_ch.data[9:0];
              RegCalYLo:  cal_y_low <= cfg_ch.data[9:0];
              RegCalXHi:  cal_x_high <= cfg_ch.data[9:0];
              RegCalYHi:  cal_y_high <= cfg_ch.data[9:0];
              RegSmooth:  smoothness <= cfg_ch.data[7:0];
              RegJitter:  jitter_delay_ms <= cfg_ch.data;
              RegTapping: tapping_delay_ms <= cfg_ch.data;
              default: ;
            endcase
          end else if (in_ch.valid) begin
            b <= in_ch.rx_byte;
            nres <= '0;
            oidx <= 1'b0;
            state <= (in_ch.opcode == OpTick) ? S_TICK : S_BYTE;
          end
        end
        S_TICK: begin
          if (ms_since_up != TimeMax) ms_since_up <= ms_since_up + 1'b1;
          if (release_pending && release_countdown <= 16'd1) begin
            release_pending <= 1'b0;
            release_countdown <= '0;
            pre_tap <= 1'b0;
            res[0] <= '{prev_touch ? EvPress : EvRelease, avg_x, avg_y, 1'b1};
            nres <= 2'd1;
            state <= S_OUT;
          end else begin
            if (release_pending) release_countdown <= release_countdown - 16'd1;
            state <= S_IDLE;
          end
        end
        S_BYTE: begin
          if (binary && ((bc0 == CntBits'(2)) == b[7])) begin
            if (b[7]) begin
              packet_store[0] <= b;
              byte_count <= CntBits'(1);
            end else begin
              byte_count <= '0;
            end
            state <= S_IDLE;
          end else if (!binary && bc0 == '0 && b != ChT && b != ChR) begin
            byte_count <= bc0;
            state <= S_IDLE;
          end else begin
            packet_store[bc0[IdxBits-1:0]] <= b;
            if (!binary && b == ChCr && bc0 + 1'b1 != plen) begin
              byte_count <= '0;
              state <= S_IDLE;
            end else if (bc0 + 1'b1 != plen) begin
              byte_count <= bc0 + 1'b1;
              state <= S_IDLE;
            end else begin
              byte_count <= '0;
              axis <= 1'b0;
              if (binary) begin
                button <= b[6];
                raw_x <= format_mode[1] ? {2'b00, packet_store[0][6:0], packet_store[1][6]}
                                        : {packet_store[0][6:0], packet_store[1][6:4]};
                raw_y <= format_mode[1] ? {2'b00, packet_store[1][3:0], b[5:2]}
                                        : {packet_store[1][3:0], b[5:0]};
                state <= S_CAL_START;
              end else begin
                button <= (packet_store[0] == ChT);
                pidx <= IdxBits'(1);
                pphase <= 2'd0;
                neg <= 1'b0;
                mag <= '0;
                state <= S_PARSE;
              end
            end
          end
        end
        S_PARSE: begin
          // phase 0 skips space and takes a sign, 2 digits, 3 ends the field; at most one character a cycle
          if (pphase == 2'd0 && is_sp && pidx != IdxBits'(PACKET_BYTES - 1)) begin
            pidx <= pidx + 1'b1;
          end else if (pphase == 2'd0 && is_sp) begin
            pphase <= 2'd3;
          end else if (pphase == 2'd0) begin
            if (cur == ChPlus || cur == ChMinus) begin
              neg <= (cur == ChMinus);
              if (pidx == IdxBits'(PACKET_BYTES - 1)) pphase <= 2'd3;
              else begin pidx <= pidx + 1'b1; pphase <= 2'd2; end
            end else pphase <= 2'd2;
          end else if (pphase == 2'd2 && is_dig) begin
            mag <= mag_sat;
            if (pidx == IdxBits'(PACKET_BYTES - 1)) pphase <= 2'd3;
            else pidx <= pidx + 1'b1;
          end else begin
            if ((neg && mag_div != 0) || mag_div > 16'd1023) begin
              state <= S_IDLE;
            end else if (!axis) begin
              raw_x <= mag_div[9:0];
              axis <= 1'b1;
              pidx <= IdxBits'(6);
              pphase <= 2'd0;
              neg <= 1'b0;
              mag <= '0;
            end else begin
              raw_y <= mag_div[9:0];
              axis <= 1'b0;
              state <= S_CAL_START;
            end
          end
        end
        S_CAL_START: begin
          dreq.num <= 32'(diff_abs) * 32'd49152;
          dreq.den <= {5'd0, den_abs};
          state <= S_CAL_WAIT;
        end
        S_CAL_WAIT: begin
          if (drsp.done) begin
            if (!axis) begin
              vx <= cal_sat;
              axis <= 1'b1;
              state <= S_CAL_START;
            end else begin
              vy <= 16'hffff - cal_sat;
              axis <= 1'b0;
              state <= pen_was_up ? S_EVENTS : S_SM_START;
            end
          end
        end
        S_SM_START: begin
          dreq.num <= {8'd0, sm_num};
          dreq.den <= {7'd0, {1'b0, smoothness} + 9'd1};
          state <= S_SM_WAIT;
        end
        S_SM_WAIT: begin
          if (drsp.done) begin
            if (!axis) begin
              vx <= drsp.quo[15:0];
              axis <= 1'b1;
              state <= S_SM_START;
            end else begin
              vy <= drsp.quo[15:0];
              state <= S_EVENTS;
            end
          end
        end
        S_EVENTS: begin
          logic [1:0] n;
          n = '0;
          if (avg_x != vx || avg_y != vy) begin
            res[0] <= '{EvMotion, vx, vy, 1'b0};
            n = 2'd1;
          end
          if (!prev_touch && button) begin
            if (release_pending) begin
              release_pending <= 1'b0;
              release_countdown <= '0;
            end else if (tapping_delay_ms == 0 ||
                         33'(ms_since_up) < 33'(tapping_delay_ms)) begin
              res[n[0]] <= '{EvPress, vx, vy, 1'b0};
              n = n + 2'd1;
            end else pre_tap <= 1'b1;
          end else if (prev_touch && !button) begin
            ms_since_up <= '0;
            if (jitter_delay_ms != 0) begin
              release_pending <= 1'b1;
              release_countdown <= jitter_delay_ms;
            end else begin
              if (!pre_tap) begin
                res[n[0]] <= '{EvRelease, vx, vy, 1'b0};
                n = n + 2'd1;
              end
              pre_tap <= 1'b0;
            end
          end
          pen_was_up <= !button;
          prev_touch <= button;
          avg_x <= vx;
          avg_y <= vy;
          nres <= n;
          state <= (n == 2'd0) ? S_IDLE : S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (oidx == 1'b0 && nres == 2'd2) oidx <= 1'b1;
            else state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/touch_packet_decode_debounce.sv */
// A closing packet is decoded (decimal parse one character a cycle), then calibrated and smoothed
// with up to four divides on the shared divider, two per step, one per axis.
// Throughput: one item at a time; ready is low until all results are taken.
// Reset: synchronous active-high rst restores register defaults and clears the control and debounce state.
module touch_packet_decode_debounce #(
  parameter int PACKET_BYTES = tpdd_pkg::PacketBytes,
  parameter int TIME_BITS = tpdd_pkg::TimeBits
) (
  input logic clk,
  input logic rst,
  tpdd_in_if.sink in_ch,
  tpdd_out_if.source out_ch,
  tpdd_cfg_if.sink cfg_ch
);
  import tpdd_pkg::*;
  div_req_t dreq;
  div_rsp_t drsp;

  tpdd_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  tpdd_core #(.PACKET_BYTES(PACKET_BYTES), .TIME_BITS(TIME_BITS)) u_core (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .dreq(dreq), .drsp(drsp)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    dreq.start |=> drsp.busy) else $error("divider did not start");
`endif
endmodule
